@@ sv/isrf_pkg.sv @@
// Shared types, codes and constants of the sensor register file.
package isrf_pkg;

    typedef enum logic [2:0] {
        FuncStart = 3'd0,
        FuncStop  = 3'd1,
        FuncWrite = 3'd2,
        FuncRead  = 3'd3,
        FuncTick  = 3'd4
    } t_func;

    typedef struct packed {
        logic       ack;
        logic [7:0] read_data;
        logic       ready_pin;
    } t_result;

    localparam int BankDepth = 16;
    localparam int BankAw    = $clog2(BankDepth);

    localparam logic [7:0]  WrLow      = 8'h04;
    localparam logic [7:0]  WrHigh     = 8'h0F;
    localparam logic [7:0]  MeasReg    = 8'h0F;
    localparam logic [15:0] DelayReset = 16'd660;

    // Register index of the delay setting on the configuration port.
    localparam logic        CfgDelayIdx = 1'b0;
    localparam int          CfgAddrW    = 3;

    // Temperature code: floor(n * 256 / 165) = (n * TempRecip) >> 24, exact for n < 2^16.
    localparam logic signed [16:0] TempOffset = 17'sd10240;
    localparam logic [24:0] TempRecip = 25'd26030105;
    // Humidity code: floor(h * 64 / 25) = (h * HumRecip) >> 22, exact for h < 2^15.
    localparam logic [23:0] HumRecip  = 24'd10737419;

    function automatic logic [7:0] id_byte(input logic [1:0] sel);
        logic [7:0] b;
        unique case (sel)
            2'd0:    b = 8'h49;
            2'd1:    b = 8'h54;
            2'd2:    b = 8'hD0;
            default: b = 8'h07;
        endcase
        return b;
    endfunction

endpackage

@@ sv/i2c_sensor_register_file.sv @@
// Register file of an I2C temperature/humidity sensor with pointer auto-increment.
// Each accepted item's result is registered into the result register, or into the skid
// register while the result register is stalled. Throughput: one item per cycle while the
// skid register is empty; this two-entry output stage keeps input acceptance going while a result waits to be taken.
// Reset (synchronous, active low) clears the bank, pointer, countdown and flags,
// empties the output stage and sets the measurement delay to 660 ticks.
module i2c_sensor_register_file (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_func,
    input  logic [7:0]                          i_wr_data,
    input  logic signed [15:0]                  i_temperature_q8,
    input  logic [14:0]                         i_humidity_q8,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_ack,
    output logic [7:0]                          o_read_data,
    output logic                                o_ready_pin,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [isrf_pkg::CfgAddrW-1:0]       paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [7:0]  r_bank [isrf_pkg::BankDepth];
    logic [7:0]  r_ptr;
    logic        r_ptr_loaded;
    logic [15:0] r_count;
    logic        r_measuring;
    logic        r_ready_level;
    logic [15:0] r_delay;

    logic [7:0]  n_bank [isrf_pkg::BankDepth];
    logic [7:0]  n_ptr;
    logic        n_ptr_loaded;
    logic [15:0] n_count;
    logic        n_measuring;
    logic        n_ready_level;

    isrf_pkg::t_result r_out;
    isrf_pkg::t_result r_skid;
    logic              r_out_vld;
    logic              r_skid_vld;
    isrf_pkg::t_result n_res;

    logic accept;
    logic out_fire;
    logic cfg_wr;

    logic signed [16:0] temp_n;
    logic [40:0]        temp_prod;
    logic [15:0]        temp_code;
    logic [38:0]        hum_prod;
    logic [15:0]        hum_raw;
    logic [7:0]         rd_byte;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign prdata     = (paddr[2] == isrf_pkg::CfgDelayIdx) ? {16'd0, r_delay} : 32'd0;

    assign o_in_ready = !r_skid_vld;
    assign accept     = i_in_valid && o_in_ready;
    assign out_fire   = r_out_vld && i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_ack       = r_out.ack;
    assign o_read_data = r_out.read_data;
    assign o_ready_pin = r_out.ready_pin;

    // Raw codes by reciprocal multiplication; a negative offset temperature clamps to zero, overflow to all ones.
    always_comb begin
        temp_n    = 17'(i_temperature_q8) + isrf_pkg::TempOffset;
        temp_prod = 41'(temp_n[15:0]) * 41'(isrf_pkg::TempRecip);
        if (temp_n[16]) begin
            temp_code = 16'd0;
        end else if (temp_prod[40]) begin
            temp_code = 16'hFFFF;
        end else begin
            temp_code = temp_prod[39:24];
        end
        hum_prod = 39'(i_humidity_q8) * 39'(isrf_pkg::HumRecip);
        hum_raw  = hum_prod[38] ? 16'hFFFF : hum_prod[37:22];
    end

    always_comb begin
        if (r_ptr[7:4] == 4'd0) begin
            rd_byte = r_bank[r_ptr[isrf_pkg::BankAw-1:0]];
        end else if (r_ptr[7:2] == 6'h3F) begin
            rd_byte = isrf_pkg::id_byte(r_ptr[1:0]);
        end else begin
            rd_byte = 8'd0;
        end
    end

    always_comb begin
        n_bank        = r_bank;
        n_ptr         = r_ptr;
        n_ptr_loaded  = r_ptr_loaded;
        n_count       = r_count;
        n_measuring   = r_measuring;
        n_ready_level = r_ready_level;
        n_res.ack       = 1'b1;
        n_res.read_data = 8'd0;
        unique case (isrf_pkg::t_func'(i_func))
            isrf_pkg::FuncStop: begin
                n_ptr_loaded = 1'b0;
            end
            isrf_pkg::FuncWrite: begin
                if (!r_ptr_loaded) begin
                    n_ptr        = i_wr_data;
                    n_ptr_loaded = 1'b1;
                end else if (r_ptr >= isrf_pkg::WrLow && r_ptr <= isrf_pkg::WrHigh) begin
                    n_bank[r_ptr[isrf_pkg::BankAw-1:0]] = i_wr_data;
                    if (r_ptr == isrf_pkg::MeasReg && i_wr_data[0]) begin
                        n_count       = (r_delay == 16'd0) ? 16'd1 : r_delay;
                        n_measuring   = 1'b1;
                        n_ready_level = 1'b0;
                    end
                    n_ptr = r_ptr + 8'd1;
                end else begin
                    n_res.ack = 1'b0;
                end
            end
            isrf_pkg::FuncRead: begin
                n_res.read_data = rd_byte;
                n_ptr           = r_ptr + 8'd1;
            end
            isrf_pkg::FuncTick: begin
                if (r_measuring) begin
                    if (r_count <= 16'd1) begin
                        n_bank[0]  = temp_code[7:0];
                        n_bank[1]  = temp_code[15:8];
                        n_bank[2]  = hum_raw[7:0];
                        n_bank[3]  = hum_raw[15:8];
                        n_bank[isrf_pkg::MeasReg[isrf_pkg::BankAw-1:0]] =
                            r_bank[isrf_pkg::MeasReg[isrf_pkg::BankAw-1:0]] & 8'hFE;
                        n_ready_level = 1'b1;
                        n_measuring   = 1'b0;
                        n_count       = 16'd0;
                    end else begin
                        n_count = r_count - 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        n_res.ready_pin = n_ready_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < isrf_pkg::BankDepth; i++) begin
                r_bank[i] <= 8'd0;
            end
            r_ptr         <= 8'd0;
            r_ptr_loaded  <= 1'b0;
            r_count       <= 16'd0;
            r_measuring   <= 1'b0;
            r_ready_level <= 1'b0;
        end else if (accept) begin
            r_bank        <= n_bank;
            r_ptr         <= n_ptr;
            r_ptr_loaded  <= n_ptr_loaded;
            r_count       <= n_count;
            r_measuring   <= n_measuring;
            r_ready_level <= n_ready_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= isrf_pkg::DelayReset;
        end else if (cfg_wr && paddr[2] == isrf_pkg::CfgDelayIdx) begin
            r_delay <= pwdata[15:0];
        end
    end

    // Output stage: a beat that arrives while the result register is stalled parks in the skid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || out_fire) begin
            r_out_vld  <= r_skid_vld || accept;
            r_skid_vld <= 1'b0;
        end else if (accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || out_fire) begin
            r_out <= r_skid_vld ? r_skid : n_res;
        end
        if (accept && r_out_vld && !out_fire) begin
            r_skid <= n_res;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid while result register empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_vld && !i_out_ready) |=> r_skid_vld)
        else $error("beat accepted under stall was not parked in skid");

    a_ready_vs_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ready_level && r_measuring))
        else $error("ready pin high while a measurement runs");

    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_measuring |-> (r_count != 16'd0))
        else $error("measurement running with zero countdown");

endmodule
